/* sv/xsrr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xsrr_pkg: shared types and constants of the xorshift32 range generator
// Holds the transaction payload structs, the mode and state codes, the
// generator constants and the single xorshift step.
// ----------------------------------------------------------------------------
package xsrr_pkg;

    localparam int unsigned WordW = 32;

    localparam logic [WordW-1:0] DefaultSeed = 32'd2463534242;
    localparam logic [WordW-1:0] AccInit     = 32'h9E37_79B9;
    localparam logic [WordW-1:0] LcgMul      = 32'd1664525;
    localparam logic [WordW-1:0] LcgAdd      = 32'd1013904223;
    localparam logic [WordW-1:0] AvalMul     = 32'h045D_9F3B;

    typedef enum logic [1:0] {
        MODE_DRAW   = 2'd0,
        MODE_ABSORB = 2'd1,
        MODE_SEED   = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_MOD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [WordW-1:0] range_low;
        logic signed [WordW-1:0] range_high;
        logic [WordW-1:0]        entropy_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [WordW-1:0] drawn_value;
        logic [WordW-1:0]        raw_word;
    } t_out_item;

    // One xorshift32 step with shifts 13, 17 and 5.
    function automatic logic [WordW-1:0] xs_step(input logic [WordW-1:0] x);
        logic [WordW-1:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage
`default_nettype wire

/* sv/xsrr_serial_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xsrr_serial_mul: bit-serial multiplier, product modulo 2^32
// Scans the multiplier one bit per cycle, least significant first, and adds
// the left-shifting multiplicand into the accumulator.
// ----------------------------------------------------------------------------
module xsrr_serial_mul
    import xsrr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WordW-1:0] i_a,
    input  wire logic [WordW-1:0] i_b,
    output logic                  o_done,
    output logic [WordW-1:0]      o_product
);

    localparam int unsigned CntW = $clog2(WordW);

    logic [WordW-1:0] r_a, n_a;
    logic [WordW-1:0] r_b, n_b;
    logic [WordW-1:0] r_acc, n_acc;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = r_b[0] ? (r_acc + r_a) : r_acc;
            n_a   = r_a << 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(WordW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule
`default_nettype wire

/* sv/xsrr_serial_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xsrr_serial_mod: bit-serial restoring remainder unit
// Shifts the dividend into a partial remainder one bit per cycle and
// subtracts the divisor whenever it fits. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module xsrr_serial_mod
    import xsrr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WordW-1:0] i_dividend,
    input  wire logic [WordW-1:0] i_divisor,
    output logic                  o_done,
    output logic [WordW-1:0]      o_remainder
);

    localparam int unsigned CntW = $clog2(WordW);

    logic [WordW-1:0] r_x, n_x;
    logic [WordW-1:0] r_div, n_div;
    logic [WordW-1:0] r_rem, n_rem;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [WordW:0]   trial;
    logic [WordW:0]   diff;

    always_comb begin
        trial  = {r_rem, r_x[WordW-1]};
        diff   = trial - {1'b0, r_div};
        n_x    = r_x;
        n_div  = r_div;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_x    = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so the trial
            // value is below twice the divisor and one subtract suffices.
            n_rem = (trial >= {1'b0, r_div}) ? diff[WordW-1:0] : trial[WordW-1:0];
            n_x   = r_x << 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(WordW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_div <= n_div;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

/* sv/xorshift32_range_rng.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xorshift32_range_rng: xorshift32 generator with range draw and seeding
// Draws values in a signed half-open range, folds entropy samples into a
// seed accumulator and loads a finalized seed into the generator.
// ----------------------------------------------------------------------------
// One transaction is in work at a time. A range draw runs through the
// bit-serial remainder unit (ST_MOD), and an entropy fold or a seed load runs
// through the bit-serial multiplier (ST_MUL). Either way the result then
// passes ST_DONE into the output register, and the next transaction can be
// accepted once the state is back in ST_IDLE. An empty or inverted range and
// the unused mode skip the serial units and go straight from acceptance to
// ST_DONE. The result sits in an output register, so the next transaction is
// accepted while it waits. A finished result that finds the output register
// still occupied waits in ST_DONE until that register is taken.
// ----------------------------------------------------------------------------
module xorshift32_range_rng
    import xsrr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    t_state           r_state, n_state;
    logic [WordW-1:0] r_gen, n_gen;
    logic [WordW-1:0] r_acc, n_acc;
    t_mode            r_mode, n_mode;
    logic [WordW-1:0] r_lo, n_lo;
    t_out_item        r_res, n_res;
    t_out_item        r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             mul_start, mul_done;
    logic [WordW-1:0] mul_a, mul_b, mul_product;
    logic             mod_start, mod_done;
    logic [WordW-1:0] mod_dividend, mod_divisor, mod_remainder;

    logic [WordW-1:0] stepped;
    logic [WordW-1:0] folded;
    logic [WordW-1:0] finished;
    t_mode            in_mode;

    xsrr_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    xsrr_serial_mod u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (mod_start),
        .i_dividend  (mod_dividend),
        .i_divisor   (mod_divisor),
        .o_done      (mod_done),
        .o_remainder (mod_remainder)
    );

    always_comb begin
        n_state      = r_state;
        n_gen        = r_gen;
        n_acc        = r_acc;
        n_mode       = r_mode;
        n_lo         = r_lo;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        mul_start    = 1'b0;
        mul_a        = r_acc ^ (r_acc >> 16);
        mul_b        = AvalMul;
        mod_start    = 1'b0;
        mod_dividend = xs_step(r_gen);
        mod_divisor  = i_in_data.range_high - i_in_data.range_low;
        in_mode      = t_mode'(i_in_data.mode);
        stepped      = xs_step(r_gen);
        folded       = mul_product + LcgAdd;
        finished     = mul_product ^ (mul_product >> 16);
        o_in_ready   = (r_state == ST_IDLE);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode = in_mode;
                    n_lo   = i_in_data.range_low;
                    unique case (in_mode)
                        MODE_DRAW: begin
                            if (i_in_data.range_high <= i_in_data.range_low) begin
                                n_res.drawn_value = i_in_data.range_low;
                                n_res.raw_word    = r_gen;
                                n_state           = ST_DONE;
                            end else begin
                                n_gen     = stepped;
                                mod_start = 1'b1;
                                n_state   = ST_MOD;
                            end
                        end
                        MODE_ABSORB: begin
                            mul_a     = r_acc ^ i_in_data.entropy_sample;
                            mul_b     = LcgMul;
                            mul_start = 1'b1;
                            n_state   = ST_MUL;
                        end
                        MODE_SEED: begin
                            mul_start = 1'b1;
                            n_state   = ST_MUL;
                        end
                        MODE_UNUSED: begin
                            n_res.drawn_value = '0;
                            n_res.raw_word    = r_gen;
                            n_state           = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_res.drawn_value = '0;
                    if (r_mode == MODE_ABSORB) begin
                        n_acc          = folded;
                        n_res.raw_word = r_gen;
                    end else begin
                        // A finalized seed of zero would lock the generator.
                        n_gen          = (finished == '0) ? DefaultSeed : finished;
                        n_acc          = AccInit;
                        n_res.raw_word = n_gen;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    n_res.drawn_value = r_lo + mod_remainder;
                    n_res.raw_word    = r_gen;
                    n_state           = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_lo   <= n_lo;
        r_res  <= n_res;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gen       <= DefaultSeed;
            r_acc       <= AccInit;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

/* tb/tb_xorshift32_range_rng.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xorshift32_range_rng: self-checking bench for the xorshift32 range generator
// Walks a directed table (empty and inverted ranges, full-width spans, entropy
// folds, seed loads including the zero-seed fallback, the unused mode) and then
// a long random run. Every result is checked against a local predictor or a
// fixed expected value, and both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_xorshift32_range_rng
    import xsrr_pkg::*;
();

    localparam logic [WordW-1:0] IntMin = 32'h8000_0000;
    localparam logic [WordW-1:0] IntMax = 32'h7FFF_FFFF;
    localparam int RandomItems = 550;
    localparam int DrainCycles = 60;
    localparam int MaxReports  = 10;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Predictor state, updated once per accepted input transaction.
    logic [WordW-1:0] gen_state = DefaultSeed;
    logic [WordW-1:0] seed_acc  = AccInit;

    t_out_item pending_results[$];
    t_dir_row  directed_rows[$];
    int        fail_cnt  = 0;
    bit        in_quiet  = 1'b0;
    bit        out_quiet = 1'b0;
    logic [WordW-1:0] acc_zeroing_word;

    xorshift32_range_rng u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #3ms;
        $display("tb_xorshift32_range_rng failed");
        $finish;
    end

    function automatic t_out_item next_rng_result(input t_in_item it);
        t_out_item        r;
        logic [WordW-1:0] span;
        logic [WordW-1:0] x;
        r.drawn_value = '0;
        case (t_mode'(it.mode))
            MODE_DRAW: begin
                if ($signed(it.range_high) <= $signed(it.range_low)) begin
                    r.drawn_value = it.range_low;
                end else begin
                    span = it.range_high - it.range_low;
                    x = gen_state;
                    x = x ^ (x << 13);
                    x = x ^ (x >> 17);
                    x = x ^ (x << 5);
                    gen_state = x;
                    r.drawn_value = it.range_low + (x % span);
                end
            end
            MODE_ABSORB: begin
                seed_acc = (seed_acc ^ it.entropy_sample) * LcgMul + LcgAdd;
            end
            MODE_SEED: begin
                x = seed_acc;
                x = x ^ (x >> 16);
                x = x * AvalMul;
                x = x ^ (x >> 16);
                gen_state = (x == '0) ? DefaultSeed : x;
                seed_acc = AccInit;
            end
            default: ;
        endcase
        r.raw_word = gen_state;
        return r;
    endfunction

    // Value v with v * LcgMul + LcgAdd == 0, so that folding (acc ^ v) leaves
    // the accumulator at zero and the next seed load falls back to the default.
    function automatic logic [WordW-1:0] lcg_zero_preimage();
        logic [WordW-1:0] inv;
        inv = LcgMul;
        repeat (5) inv = inv * (32'd2 - LcgMul * inv);
        return (-LcgAdd) * inv;
    endfunction

    function automatic t_in_item mk_item(input t_mode m, input logic [WordW-1:0] lo,
                                         input logic [WordW-1:0] hi,
                                         input logic [WordW-1:0] smp);
        t_in_item it;
        it.mode           = m;
        it.range_low      = lo;
        it.range_high     = hi;
        it.entropy_sample = smp;
        return it;
    endfunction

    function automatic int pick_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic t_in_item random_item();
        int               pick;
        logic [WordW-1:0] lo;
        logic [WordW-1:0] hi;
        logic [WordW-1:0] smp;
        pick = $urandom_range(0, 99);
        lo  = $urandom;
        hi  = $urandom;
        smp = $urandom;
        if (pick < 50) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: hi = lo + $urandom_range(1, 100);
                4, 5:       ;
                6:          hi = lo;
                7:          lo = IntMin;
                8:          hi = IntMax;
                default:    hi = lo + (32'd1 << $urandom_range(0, 31));
            endcase
            return mk_item(MODE_DRAW, lo, hi, smp);
        end else if (pick < 78) begin
            if ($urandom_range(0, 19) == 0)
                smp = seed_acc ^ acc_zeroing_word;
            return mk_item(MODE_ABSORB, lo, hi, smp);
        end else if (pick < 93) begin
            return mk_item(MODE_SEED, lo, hi, smp);
        end
        return mk_item(MODE_UNUSED, lo, hi, smp);
    endfunction

    task automatic add_row(input t_in_item it, input bit typed,
                           input logic [WordW-1:0] drawn, input logic [WordW-1:0] raw);
        t_dir_row row;
        row.item             = it;
        row.typed            = typed;
        row.want.drawn_value = drawn;
        row.want.raw_word    = raw;
        directed_rows.push_back(row);
    endtask

    task automatic note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= MaxReports)
            $display("%0t ns: %s", $realtime, msg);
    endtask

    // Drives one transaction and records its expected result on acceptance.
    // Valid stays high across back-to-back transactions.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        t_out_item predicted;
        gap = pick_gap(in_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!o_in_ready);
        predicted = next_rng_result(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Result side: check each accepted transaction, then stall at random.
    initial begin
        t_out_item want;
        int        stall;
        stall = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (o_out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    note_fail($sformatf("unexpected result drawn=%h raw=%h",
                                        o_out_data.drawn_value, o_out_data.raw_word));
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.drawn_value !== want.drawn_value)
                        note_fail($sformatf("drawn_value expected %h got %h",
                                            want.drawn_value, o_out_data.drawn_value));
                    if (o_out_data.raw_word !== want.raw_word)
                        note_fail($sformatf("raw_word expected %h got %h",
                                            want.raw_word, o_out_data.raw_word));
                end
                stall = pick_gap(out_quiet);
            end else if (stall > 0) begin
                stall--;
            end
            out_ready <= (stall == 0);
        end
    end

    initial begin
        t_out_item none;
        none = '0;
        acc_zeroing_word = lcg_zero_preimage();

        add_row(mk_item(MODE_UNUSED, '1, '1, '1), 1'b1, '0, DefaultSeed);
        add_row(mk_item(MODE_DRAW, 32'd5, 32'd5, '0), 1'b1, 32'd5, DefaultSeed);
        add_row(mk_item(MODE_DRAW, IntMax, IntMin, '0), 1'b1, IntMax, DefaultSeed);
        add_row(mk_item(MODE_DRAW, '1, '1, '1), 1'b1, '1, DefaultSeed);
        add_row(mk_item(MODE_DRAW, IntMin, IntMax, '0), 1'b0, '0, '0);
        add_row(mk_item(MODE_DRAW, 32'd0, 32'd1, '0), 1'b0, '0, '0);
        add_row(mk_item(MODE_DRAW, IntMin, IntMin + 32'd1, '1), 1'b0, '0, '0);
        add_row(mk_item(MODE_DRAW, IntMax - 32'd1, IntMax, '0), 1'b0, '0, '0);
        add_row(mk_item(MODE_DRAW, -32'sd100, 32'sd100, '0), 1'b0, '0, '0);
        add_row(mk_item(MODE_ABSORB, '0, '0, '0), 1'b0, '0, '0);
        add_row(mk_item(MODE_ABSORB, '0, '0, '1), 1'b0, '0, '0);
        add_row(mk_item(MODE_ABSORB, '1, '1, 32'h1234_5678), 1'b0, '0, '0);
        add_row(mk_item(MODE_SEED, '0, '0, '0), 1'b0, '0, '0);
        add_row(mk_item(MODE_DRAW, 32'd0, 32'd1000, '0), 1'b0, '0, '0);
        // Accumulator is back at its initial value here; drive it to zero.
        add_row(mk_item(MODE_ABSORB, '0, '0, AccInit ^ acc_zeroing_word), 1'b0, '0, '0);
        add_row(mk_item(MODE_SEED, '1, '1, '1), 1'b1, '0, DefaultSeed);
        add_row(mk_item(MODE_DRAW, IntMin, 32'd0, '0), 1'b0, '0, '0);
        add_row(mk_item(MODE_SEED, '0, '0, '0), 1'b0, '0, '0);
        add_row(mk_item(MODE_DRAW, -32'sd7, -32'sd3, '0), 1'b0, '0, '0);
        add_row(mk_item(MODE_UNUSED, '0, '0, '0), 1'b0, '0, '0);
        add_row(mk_item(MODE_DRAW, IntMin, IntMin, '0), 1'b0, '0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < RandomItems; n++) begin
            if (n % 40 == 0) begin
                in_quiet  = ($urandom_range(0, 3) == 0);
                out_quiet = ($urandom_range(0, 3) == 0);
            end
            send_item(random_item(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (pending_results.size() != 0)
            note_fail($sformatf("%0d results never arrived", pending_results.size()));

        if (fail_cnt == 0) begin
            $display("tb_xorshift32_range_rng passed");
        end else begin
            $display("tb_xorshift32_range_rng failed");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/xsrr_pkg.sv
sv/xsrr_serial_mul.sv
sv/xsrr_serial_mod.sv
sv/xorshift32_range_rng.sv
tb/tb_xorshift32_range_rng.sv
